[rtl/core/tun_pkg.sv]
// Shared types and constants of the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int IO_WIDTH         = 16;
	localparam int LANES            = 3;

	// Control word that travels with each transaction down the pipe.
	typedef struct packed {
		logic             valid;
		logic             degen;
		logic [LANES-1:0] sign;
	} ctl_t;

endpackage

[rtl/core/tun_front.sv]
// Front pipe: edges, cross product, magnitudes, squares and squared length.
`timescale 1ns / 1ps
module tun_front #(
	parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS,
	parameter int LW               = 2 * (2 * COORD_WIDTH + 2) + 2,
	parameter int RW               = LW + 2 * NORMAL_FRAC_BITS + 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [tun_pkg::IO_WIDTH-1:0]         first_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]         first_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]         first_z,
	input  logic [tun_pkg::IO_WIDTH-1:0]         second_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]         second_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]         second_z,
	input  logic [tun_pkg::IO_WIDTH-1:0]         third_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]         third_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]         third_z,
	output tun_pkg::ctl_t                        ctl,
	output logic [LW-1:0]                        len2,
	output logic [tun_pkg::LANES-1:0][RW-1:0]    rem
);

	localparam int UW = (COORD_WIDTH < tun_pkg::IO_WIDTH) ? COORD_WIDTH : tun_pkg::IO_WIDTH;
	localparam int EW = COORD_WIDTH + 1;
	localparam int PW = 2 * EW;
	localparam int NW = PW + 1;
	localparam int AW = PW;
	localparam int H  = EW;
	localparam int HW = AW - H;
	localparam int SW = 2 * AW;
	localparam int F  = NORMAL_FRAC_BITS;

	logic signed [EW-1:0] p0 [3];
	logic signed [EW-1:0] p1 [3];
	logic signed [EW-1:0] p2 [3];

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [EW-1:0] ea_s1 [3];
	logic signed [EW-1:0] eb_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [NW-1:0] n_s3 [3];
	logic [AW-1:0]        mag_s4 [3];
	logic [2:0]           sign_s4, sign_s5, sign_s6, sign_s7;
	logic                 deg_s4, deg_s5, deg_s6, deg_s7;
	logic [2*HW-1:0]      hh_s5 [3];
	logic [HW+H-1:0]      hl_s5 [3];
	logic [2*H-1:0]       ll_s5 [3];
	logic [SW-1:0]        sq_s6 [3];
	logic [LW-1:0]        len2_s7;
	logic [RW-1:0]        rem_s7 [3];

	// Take the low coordinate bits and sign-extend them.
	always_comb begin
		p0[0] = EW'($signed(first_x[UW-1:0]));
		p0[1] = EW'($signed(first_y[UW-1:0]));
		p0[2] = EW'($signed(first_z[UW-1:0]));
		p1[0] = EW'($signed(second_x[UW-1:0]));
		p1[1] = EW'($signed(second_y[UW-1:0]));
		p1[2] = EW'($signed(second_z[UW-1:0]));
		p2[0] = EW'($signed(third_x[UW-1:0]));
		p2[1] = EW'($signed(third_y[UW-1:0]));
		p2[2] = EW'($signed(third_z[UW-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ea_s1[c] <= p1[c] - p0[c];
			eb_s1[c] <= p2[c] - p0[c];
		end
		// Cross product terms, each pair subtracted in the next stage.
		p_s2[0] <= PW'(ea_s1[1]) * PW'(eb_s1[2]);
		p_s2[1] <= PW'(ea_s1[2]) * PW'(eb_s1[1]);
		p_s2[2] <= PW'(ea_s1[2]) * PW'(eb_s1[0]);
		p_s2[3] <= PW'(ea_s1[0]) * PW'(eb_s1[2]);
		p_s2[4] <= PW'(ea_s1[0]) * PW'(eb_s1[1]);
		p_s2[5] <= PW'(ea_s1[1]) * PW'(eb_s1[0]);
		for (int c = 0; c < 3; c++) begin
			n_s3[c] <= NW'(p_s2[2*c]) - NW'(p_s2[2*c+1]);
		end
		for (int c = 0; c < 3; c++) begin
			mag_s4[c]  <= n_s3[c][NW-1] ? AW'(-n_s3[c]) : AW'(n_s3[c]);
			sign_s4[c] <= n_s3[c][NW-1];
		end
		deg_s4 <= (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
		// Square each magnitude from three half-width products.
		for (int c = 0; c < 3; c++) begin
			hh_s5[c] <= mag_s4[c][AW-1:H] * mag_s4[c][AW-1:H];
			hl_s5[c] <= mag_s4[c][AW-1:H] * mag_s4[c][H-1:0];
			ll_s5[c] <= mag_s4[c][H-1:0] * mag_s4[c][H-1:0];
		end
		sign_s5 <= sign_s4;
		deg_s5  <= deg_s4;
		for (int c = 0; c < 3; c++) begin
			sq_s6[c] <= (SW'(hh_s5[c]) << (2 * H)) + (SW'(hl_s5[c]) << (H + 1))
				+ SW'(ll_s5[c]);
		end
		sign_s6 <= sign_s5;
		deg_s6  <= deg_s5;
		len2_s7 <= LW'(sq_s6[0]) + LW'(sq_s6[1]) + LW'(sq_s6[2]);
		for (int c = 0; c < 3; c++) begin
			rem_s7[c] <= RW'(sq_s6[c]) << (2 * F);
		end
		sign_s7 <= sign_s6;
		deg_s7  <= deg_s6;
	end

	assign ctl.valid = v_s7;
	assign ctl.degen = deg_s7;
	assign ctl.sign  = sign_s7;
	assign len2      = len2_s7;
	assign rem[0]    = rem_s7[0];
	assign rem[1]    = rem_s7[1];
	assign rem[2]    = rem_s7[2];

endmodule

[rtl/core/tun_cell.sv]
// One quotient-bit cell of the normalizing chain, three lanes wide.
`timescale 1ns / 1ps
module tun_cell #(
	parameter int BIT = 0,
	parameter int QW  = 15,
	parameter int LW  = 70,
	parameter int RW  = 101
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tun_pkg::ctl_t                        ctl_in,
	input  logic [LW-1:0]                        len2_in,
	input  logic [tun_pkg::LANES-1:0][RW-1:0]    rem_in,
	input  logic [tun_pkg::LANES-1:0][RW-1:0]    ql_in,
	input  logic [tun_pkg::LANES-1:0][QW-1:0]    q_in,
	output tun_pkg::ctl_t                        ctl_out,
	output logic [LW-1:0]                        len2_out,
	output logic [tun_pkg::LANES-1:0][RW-1:0]    rem_out,
	output logic [tun_pkg::LANES-1:0][RW-1:0]    ql_out,
	output logic [tun_pkg::LANES-1:0][QW-1:0]    q_out
);

	logic [tun_pkg::LANES-1:0][RW-1:0] dlt;
	logic [tun_pkg::LANES-1:0]         take;

	// Setting this bit raises q^2*L by 2^(b+1)*qL + 2^(2b)*L.
	always_comb begin
		for (int c = 0; c < tun_pkg::LANES; c++) begin
			dlt[c]  = (ql_in[c] << (BIT + 1)) + (RW'(len2_in) << (2 * BIT));
			take[c] = (dlt[c] <= rem_in[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		len2_out <= len2_in;
		for (int c = 0; c < tun_pkg::LANES; c++) begin
			if (take[c]) begin
				rem_out[c] <= rem_in[c] - dlt[c];
				ql_out[c]  <= ql_in[c] + (RW'(len2_in) << BIT);
				q_out[c]   <= q_in[c] | (QW'(1) << BIT);
			end else begin
				rem_out[c] <= rem_in[c];
				ql_out[c]  <= ql_in[c];
				q_out[c]   <= q_in[c];
			end
		end
	end

endmodule

[rtl/core/triangle_unit_normal_unit.sv]
// Top level of the triangle unit normal block: front pipe, cell chain, result register.
`timescale 1ns / 1ps
// Takes one triangle per clock when start is high (busy is tied low, so every
// start is a transaction) and returns its unit face normal in signed
// Q1.NORMAL_FRAC_BITS, marked by a one-cycle done strobe. The block is a
// seven-stage front pipe (edges, cross product, magnitude, split square,
// squared length) followed by one cell per quotient bit and an output
// register. The receiver cannot stall: results must be taken in the cycle
// that done is high. Components are truncated toward zero; a triangle with a
// zero cross product gives a zero normal with degenerate set.
module triangle_unit_normal_unit #(
	parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tun_pkg::IO_WIDTH-1:0]  first_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]  first_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]  first_z,
	input  logic [tun_pkg::IO_WIDTH-1:0]  second_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]  second_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]  second_z,
	input  logic [tun_pkg::IO_WIDTH-1:0]  third_x,
	input  logic [tun_pkg::IO_WIDTH-1:0]  third_y,
	input  logic [tun_pkg::IO_WIDTH-1:0]  third_z,
	output logic                          done,
	output logic [tun_pkg::IO_WIDTH-1:0]  normal_x,
	output logic [tun_pkg::IO_WIDTH-1:0]  normal_y,
	output logic [tun_pkg::IO_WIDTH-1:0]  normal_z,
	output logic                          degenerate
);

	localparam int F  = NORMAL_FRAC_BITS;
	localparam int QW = F + 1;
	localparam int LW = 2 * (2 * COORD_WIDTH + 2) + 2;
	localparam int RW = LW + 2 * F + 3;
	localparam int OW = (QW > tun_pkg::IO_WIDTH) ? QW : tun_pkg::IO_WIDTH;
	localparam int NC = F + 1;

	// Chain taps: tap k feeds the cell that decides bit F-k.
	tun_pkg::ctl_t                       ctl_c  [NC+1];
	logic [LW-1:0]                       len2_c [NC+1];
	logic [tun_pkg::LANES-1:0][RW-1:0]   rem_c  [NC+1];
	logic [tun_pkg::LANES-1:0][RW-1:0]   ql_c   [NC+1];
	logic [tun_pkg::LANES-1:0][QW-1:0]   q_c    [NC+1];

	logic [tun_pkg::LANES-1:0][OW-1:0]   sgn_q;
	logic                                done_q;
	logic [tun_pkg::LANES-1:0][tun_pkg::IO_WIDTH-1:0] nrm_q;
	logic                                deg_q;

	// Every start is taken; the pipe never holds off a new triangle.
	assign busy = 1'b0;

	tun_front #(
		.COORD_WIDTH      (COORD_WIDTH),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
		.LW               (LW),
		.RW               (RW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.first_x  (first_x),
		.first_y  (first_y),
		.first_z  (first_z),
		.second_x (second_x),
		.second_y (second_y),
		.second_z (second_z),
		.third_x  (third_x),
		.third_y  (third_y),
		.third_z  (third_z),
		.ctl      (ctl_c[0]),
		.len2     (len2_c[0]),
		.rem      (rem_c[0])
	);

	// The running q*L and the quotient start at zero for every triangle.
	assign ql_c[0] = '0;
	assign q_c[0]  = '0;

	// One cell per quotient bit, most significant first. Each cell tries its
	// bit against the remaining budget a^2*2^(2F) - q^2*L and passes the
	// transaction on to its neighbor the next cycle.
	for (genvar k = 0; k < NC; k++) begin : g_cell
		tun_cell #(
			.BIT (F - k),
			.QW  (QW),
			.LW  (LW),
			.RW  (RW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[k]),
			.len2_in  (len2_c[k]),
			.rem_in   (rem_c[k]),
			.ql_in    (ql_c[k]),
			.q_in     (q_c[k]),
			.ctl_out  (ctl_c[k+1]),
			.len2_out (len2_c[k+1]),
			.rem_out  (rem_c[k+1]),
			.ql_out   (ql_c[k+1]),
			.q_out    (q_c[k+1])
		);
	end

	// Apply the component sign; wrap to the output width.
	always_comb begin
		for (int c = 0; c < tun_pkg::LANES; c++) begin
			sgn_q[c] = ctl_c[NC].sign[c] ? OW'(-OW'(q_c[NC][c])) : OW'(q_c[NC][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[NC].valid;
		end
	end

	// Result register; a degenerate triangle drops to a zero normal.
	always_ff @(posedge clk) begin
		deg_q <= ctl_c[NC].degen;
		for (int c = 0; c < tun_pkg::LANES; c++) begin
			nrm_q[c] <= ctl_c[NC].degen ? '0 : sgn_q[c][tun_pkg::IO_WIDTH-1:0];
		end
	end

	assign done       = done_q;
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign degenerate = deg_q;

endmodule

[bench/triangle_unit_normal_unit_checker.sv]
// Checker of the triangle unit normal block: predicts each normal and compares the results.
`timescale 1ns / 1ps
module triangle_unit_normal_unit_checker (
	input  logic                         clk,
	input  logic                         start,
	input  logic                         busy,
	input  logic [tun_pkg::IO_WIDTH-1:0] first_x,
	input  logic [tun_pkg::IO_WIDTH-1:0] first_y,
	input  logic [tun_pkg::IO_WIDTH-1:0] first_z,
	input  logic [tun_pkg::IO_WIDTH-1:0] second_x,
	input  logic [tun_pkg::IO_WIDTH-1:0] second_y,
	input  logic [tun_pkg::IO_WIDTH-1:0] second_z,
	input  logic [tun_pkg::IO_WIDTH-1:0] third_x,
	input  logic [tun_pkg::IO_WIDTH-1:0] third_y,
	input  logic [tun_pkg::IO_WIDTH-1:0] third_z,
	input  logic                         done,
	input  logic [tun_pkg::IO_WIDTH-1:0] normal_x,
	input  logic [tun_pkg::IO_WIDTH-1:0] normal_y,
	input  logic [tun_pkg::IO_WIDTH-1:0] normal_z,
	input  logic                         degenerate,
	output int                           fails,
	output int                           pending
);

	typedef struct packed {
		logic [tun_pkg::IO_WIDTH-1:0] nx;
		logic [tun_pkg::IO_WIDTH-1:0] ny;
		logic [tun_pkg::IO_WIDTH-1:0] nz;
		logic                         degen;
	} face_normal_t;

	face_normal_t normals_due[$];

	// Truncated quotient n_c * 2^F / |n| via bit-by-bit search on squares.
	function automatic logic [tun_pkg::IO_WIDTH-1:0] unit_component(
			input logic signed [63:0] nc, input logic [127:0] len2);
		logic [127:0] a;
		logic [127:0] target;
		logic [127:0] q;
		logic [127:0] t;
		a = nc < 0 ? -nc : nc;
		target = (a * a) << (2 * tun_pkg::NORMAL_FRAC_BITS);
		q = 0;
		for (int b = tun_pkg::NORMAL_FRAC_BITS; b >= 0; b--) begin
			t = q | (128'd1 << b);
			if (t * t * len2 <= target)
				q = t;
		end
		if (nc < 0)
			q = -q;
		return q[tun_pkg::IO_WIDTH-1:0];
	endfunction

	function automatic face_normal_t face_normal();
		logic signed [63:0] x0, y0, z0, ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [127:0] mx, my, mz, len2;
		face_normal_t r;
		x0 = $signed(first_x[tun_pkg::COORD_WIDTH-1:0]);
		y0 = $signed(first_y[tun_pkg::COORD_WIDTH-1:0]);
		z0 = $signed(first_z[tun_pkg::COORD_WIDTH-1:0]);
		ax = 64'($signed(second_x[tun_pkg::COORD_WIDTH-1:0])) - x0;
		ay = 64'($signed(second_y[tun_pkg::COORD_WIDTH-1:0])) - y0;
		az = 64'($signed(second_z[tun_pkg::COORD_WIDTH-1:0])) - z0;
		bx = 64'($signed(third_x[tun_pkg::COORD_WIDTH-1:0])) - x0;
		by = 64'($signed(third_y[tun_pkg::COORD_WIDTH-1:0])) - y0;
		bz = 64'($signed(third_z[tun_pkg::COORD_WIDTH-1:0])) - z0;
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		r = '0;
		if (cx == 0 && cy == 0 && cz == 0) begin
			r.degen = 1'b1;
			return r;
		end
		mx = cx < 0 ? -cx : cx;
		my = cy < 0 ? -cy : cy;
		mz = cz < 0 ? -cz : cz;
		len2 = mx * mx + my * my + mz * mz;
		r.nx = unit_component(cx, len2);
		r.ny = unit_component(cy, len2);
		r.nz = unit_component(cz, len2);
		return r;
	endfunction

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		face_normal_t exp_n;
		if (start && !busy)
			normals_due.push_back(face_normal());
		if (done) begin
			if (normals_due.size() == 0) begin
				$error("unexpected result: no normal pending");
				fails++;
			end else begin
				exp_n = normals_due.pop_front();
				if (normal_x !== exp_n.nx) begin
					$error("normal_x expected %0d got %0d", $signed(exp_n.nx), $signed(normal_x));
					fails++;
				end
				if (normal_y !== exp_n.ny) begin
					$error("normal_y expected %0d got %0d", $signed(exp_n.ny), $signed(normal_y));
					fails++;
				end
				if (normal_z !== exp_n.nz) begin
					$error("normal_z expected %0d got %0d", $signed(exp_n.nz), $signed(normal_z));
					fails++;
				end
				if (degenerate !== exp_n.degen) begin
					$error("degenerate expected %0b got %0b", exp_n.degen, degenerate);
					fails++;
				end
			end
		end
		pending = normals_due.size();
	end
endmodule

[bench/triangle_unit_normal_unit_test.sv]
// Testbench top of the triangle unit normal block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module triangle_unit_normal_unit_test;

	typedef logic [tun_pkg::IO_WIDTH-1:0] coord_t;

	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = tun_pkg::NORMAL_FRAC_BITS + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, degenerate;
	coord_t first_x = '0, first_y = '0, first_z = '0;
	coord_t second_x = '0, second_y = '0, second_z = '0;
	coord_t third_x = '0, third_y = '0, third_z = '0;
	coord_t normal_x, normal_y, normal_z;
	int fails, pending;
	int quiet_cycles = 0;
	int idle_pct = 0;

	always #2 clk = ~clk;

	triangle_unit_normal_unit dut (.*);

	triangle_unit_normal_unit_checker checker_i (.*);

	// Watchdog: count cycles in which neither a transaction nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("triangle_unit_normal_unit_test NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Present one triangle and hold it until the block takes the transaction.
	// Busy only moves at a rising edge, so its value at the falling edge is
	// the one the next rising edge sees.
	task automatic send_triangle(input coord_t p [9]);
		logic busy_seen;
		// Drop start for a random gap first, according to the current phase.
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		first_x  <= p[0]; first_y  <= p[1]; first_z  <= p[2];
		second_x <= p[3]; second_y <= p[4]; second_z <= p[5];
		third_x  <= p[6]; third_y  <= p[7]; third_z  <= p[8];
		start <= 1'b1;
		forever begin
			@(negedge clk);
			busy_seen = busy;
			@(posedge clk);
			if (!busy_seen)
				break;
		end
	endtask

	task automatic send_corners(input int c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z);
		coord_t p [9];
		p = '{coord_t'(c0x), coord_t'(c0y), coord_t'(c0z),
			coord_t'(c1x), coord_t'(c1y), coord_t'(c1z),
			coord_t'(c2x), coord_t'(c2y), coord_t'(c2z)};
		send_triangle(p);
	endtask

	// Random triangle; most use full-range coordinates, some stay near a small
	// origin so short edges and exact axis normals turn up, some are collinear.
	task automatic send_random();
		coord_t p [9];
		int kind;
		int k;
		kind = $urandom_range(9);
		foreach (p[i])
			p[i] = coord_t'($urandom());
		if (kind < 3) begin
			foreach (p[i])
				p[i] = p[0] + coord_t'($signed($urandom_range(8)) - 4);
		end else if (kind == 3) begin
			// Third corner on the line through the first two.
			k = $urandom_range(3);
			for (int i = 0; i < 3; i++) begin
				p[i + 3] = p[i] + coord_t'($signed($urandom_range(200)) - 100);
				p[i + 6] = p[i] + coord_t'(k) * (p[i + 3] - p[i]);
			end
		end else if (kind == 4) begin
			// All three corners share a coordinate plane: axis-aligned normal.
			k = $urandom_range(2);
			p[k + 3] = p[k];
			p[k + 6] = p[k];
		end
		send_triangle(p);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero triangle, coincident and collinear corners, axis normals
		// of both signs, extreme coordinates and their wrap-free differences.
		send_corners(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_corners(5, -7, 9, 5, -7, 9, 5, -7, 9);
		send_corners(0, 0, 0, 1, 1, 1, 2, 2, 2);
		send_corners(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
		send_corners(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_corners(0, 0, 0, 0, 1, 0, 1, 0, 0);
		send_corners(0, 0, 0, 0, 1, 0, 0, 0, 1);
		send_corners(0, 0, 0, 0, 0, 1, 1, 0, 0);
		send_corners(0, 0, 0, 0, 0, 1, 0, 1, 0);
		send_corners(0, 0, 0, 1, 0, 0, 0, 0, 1);
		send_corners(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0);
		send_corners(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
		send_corners(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
		send_corners(32767, -32768, 0, -32768, 0, 32767, 0, 32767, -32768);
		send_corners(-32768, -32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767);
		send_corners(1, 2, 3, 4, 6, 8, 2, 0, -1);
		send_corners(0, 0, 0, 1, 1, 0, 0, 1, 1);
		send_corners(-1, -1, -1, -1, -1, -1, 0, 0, 0);

		// Pause until every expected normal is back.
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < RANDOM_ITEMS / 3)
				idle_pct = 18;
			else if (n < 2 * RANDOM_ITEMS / 3)
				idle_pct = 74;
			else
				idle_pct = 0;
			send_random();
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("triangle_unit_normal_unit_test OK");
		else
			$display("triangle_unit_normal_unit_test NOT OK");
		$finish;
	end
endmodule
